// File: rtl/core/lge_pkg.sv
// Shared types and constants for the life generation engine.
// No dependencies; used by lge_row_rule and life_generation_engine.
`default_nettype none

package lge_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CELL = 4'b0010,
    ST_ADV  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam int unsigned ROWS_W = 5;
  localparam int unsigned COLS_W = 7;
  localparam int unsigned CFG_W  = 7;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 5'd10;
  localparam logic [COLS_W-1:0] COLS_RESET = 7'd35;

  localparam logic [3:0] SURVIVE_MIN = 4'd2;
  localparam logic [3:0] BIRTH_CNT   = 4'd3;

endpackage

`default_nettype wire

// File: rtl/core/lge_board_mem.sv
// Board row memory: one write port, one registered read port, per-row valid bits.
// A row never written since reset reads as all dead. Depends on nothing.
`default_nettype none

module lge_board_mem #(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    rd_en_i,
  input  wire logic [$clog2(ROWS)-1:0] rd_addr_i,
  output logic      [COLS-1:0]         rd_data_o,
  input  wire logic                    wr_en_i,
  input  wire logic [$clog2(ROWS)-1:0] wr_addr_i,
  input  wire logic [COLS-1:0]         wr_data_i
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid_q;
  logic [COLS-1:0] rd_raw_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

// File: rtl/core/lge_row_rule.sv
// Row update unit: next generation of one row from the rows above, at and below.
// Columns outside the mask keep their old value. Uses lge_pkg.
`default_nettype none

module lge_row_rule #(
  parameter int unsigned COLS = 64
) (
  input  wire logic [COLS-1:0] up_i,
  input  wire logic [COLS-1:0] mid_i,
  input  wire logic [COLS-1:0] dn_i,
  input  wire logic [COLS-1:0] mask_i,
  output logic      [COLS-1:0] next_o
);

  logic [COLS-1:0] u, m, d;
  logic [COLS-1:0] ul, ml, dl, ur, mr, dr;
  logic [COLS-1:0] born;

  assign u  = up_i & mask_i;
  assign m  = mid_i & mask_i;
  assign d  = dn_i & mask_i;
  assign ul = u << 1;
  assign ml = m << 1;
  assign dl = d << 1;
  assign ur = u >> 1;
  assign mr = m >> 1;
  assign dr = d >> 1;

  always_comb begin
    logic [3:0] n;
    born = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 4'(u[c]) + 4'(d[c]) + 4'(ul[c]) + 4'(ml[c]) + 4'(dl[c])
        + 4'(ur[c]) + 4'(mr[c]) + 4'(dr[c]);
      if (n == lge_pkg::BIRTH_CNT) begin
        born[c] = 1'b1;
      end else if (n == lge_pkg::SURVIVE_MIN) begin
        born[c] = m[c];
      end else begin
        born[c] = 1'b0;
      end
    end
  end

  assign next_o = (mid_i & ~mask_i) | (born & mask_i);

endmodule

`default_nettype wire

// File: rtl/core/life_generation_engine.sv
// Life generation engine: request channel, result channel, board size registers.
// Sequencer driving lge_board_mem and lge_row_rule; uses lge_pkg.
//
// Requests (in_valid_i / in_stall_o) carry req_type_i, row_i, col_i, alive_i:
// write a cell, read a cell, or advance the board one generation. Each request
// gives exactly one result (out_valid_o / out_stall_i) with read_alive_o and
// done_kind_o, the echo of the request type.
// One request is handled at a time; in_stall_o is high from acceptance until
// the result has been taken.
// Write and read pass through a cell step (read-modify-write of the row) and
// then give the result; an unused type goes straight to the result, as does
// an advance with no rows in use (rows in use are at most MAX_ROWS). Else an
// advance walks the rows in order: one row is read and one row written per
// cycle while a three-row window feeds the row update unit.
// Reset clears the board (per-row valid bits), the sequencer and the size
// registers (10 rows, 35 columns). A stalled result holds, and no new request
// is taken until it is delivered. Size registers are written via cfg_we_i.
`default_nettype none

module life_generation_engine #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_index_i,
  input  wire logic [lge_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [3:0]                 row_i,
  input  wire logic [5:0]                 col_i,
  input  wire logic                       alive_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            read_alive_o,
  output logic [1:0]                      done_kind_o
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned RCW = (CW > lge_pkg::ROWS_W) ? CW : lge_pkg::ROWS_W;
  localparam int unsigned CLW = $clog2(MAX_COLS);

  lge_pkg::state_e state_q, state_d;

  logic [lge_pkg::ROWS_W-1:0] rows_q;
  logic [lge_pkg::COLS_W-1:0] cols_q;
  logic [RCW-1:0]             rows_eff;
  logic [lge_pkg::COLS_W-1:0] cols_eff;
  logic [MAX_COLS-1:0]        mask;

  logic [1:0]          kind_q;
  logic [RW-1:0]       row_idx_q;
  logic [CLW-1:0]      col_idx_q;
  logic                alive_q;
  logic                in_board_q;
  logic                rbit_q, rbit_d;
  logic [RCW-1:0]      cnt_q, cnt_d;
  logic [MAX_COLS-1:0] up_q, up_d, mid_q, mid_d;

  logic                accept;
  logic                in_board;
  logic [RCW-1:0]      row_ext;
  logic [RCW-1:0]      cnt_inc;
  logic [RCW-1:0]      cnt_dec;
  logic [MAX_COLS-1:0] dn;
  logic [MAX_COLS-1:0] rule_next;

  logic                rd_en, wr_en;
  logic [RW-1:0]       rd_addr, wr_addr;
  logic [MAX_COLS-1:0] rd_data, wr_data;

  assign rows_eff = (RCW'(rows_q) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_q);
  assign cols_eff = (cols_q > lge_pkg::COLS_W'(MAX_COLS)) ?
                    lge_pkg::COLS_W'(MAX_COLS) : cols_q;

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign mask[c] = lge_pkg::COLS_W'(c) < cols_eff;
  end

  assign accept   = in_valid_i && (state_q == lge_pkg::ST_IDLE);
  assign row_ext  = RCW'(row_i);
  assign in_board = (row_ext < rows_eff) && ({1'b0, col_i} < cols_eff);
  assign cnt_inc  = cnt_q + RCW'(1);
  assign cnt_dec  = cnt_q - RCW'(1);
  assign dn       = (cnt_q < rows_eff) ? rd_data : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lge_pkg::ROWS_RESET;
      cols_q <= lge_pkg::COLS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lge_pkg::REG_ROWS: rows_q <= cfg_wdata_i[lge_pkg::ROWS_W-1:0];
        lge_pkg::REG_COLS: cols_q <= cfg_wdata_i[lge_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    rbit_d  = rbit_q;
    cnt_d   = cnt_q;
    up_d    = up_q;
    mid_d   = mid_q;
    rd_en   = 1'b0;
    rd_addr = row_ext[RW-1:0];
    wr_en   = 1'b0;
    wr_addr = cnt_dec[RW-1:0];
    wr_data = rule_next;
    unique case (state_q)
      lge_pkg::ST_IDLE: begin
        if (accept) begin
          rbit_d = 1'b0;
          unique case (lge_pkg::req_e'(req_type_i))
            lge_pkg::REQ_WRITE, lge_pkg::REQ_READ: begin
              rd_en   = 1'b1;
              state_d = lge_pkg::ST_CELL;
            end
            lge_pkg::REQ_ADVANCE: begin
              cnt_d = '0;
              up_d  = '0;
              mid_d = '0;
              if (rows_eff == '0) begin
                state_d = lge_pkg::ST_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = lge_pkg::ST_ADV;
              end
            end
            default: state_d = lge_pkg::ST_RESP;
          endcase
        end
      end
      lge_pkg::ST_CELL: begin
        wr_addr = row_idx_q;
        wr_data = rd_data;
        wr_data[col_idx_q] = alive_q;
        if (lge_pkg::req_e'(kind_q) == lge_pkg::REQ_WRITE) begin
          wr_en = in_board_q;
        end else begin
          rbit_d = in_board_q & rd_data[col_idx_q];
        end
        state_d = lge_pkg::ST_RESP;
      end
      lge_pkg::ST_ADV: begin
        wr_en   = (cnt_q != '0);
        up_d    = mid_q;
        mid_d   = dn;
        rd_en   = cnt_inc < rows_eff;
        rd_addr = cnt_inc[RW-1:0];
        cnt_d   = cnt_inc;
        if (cnt_q == rows_eff) begin
          state_d = lge_pkg::ST_RESP;
        end
      end
      lge_pkg::ST_RESP: begin
        if (!out_stall_i) begin
          state_d = lge_pkg::ST_IDLE;
        end
      end
      default: state_d = lge_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lge_pkg::ST_IDLE;
      cnt_q   <= '0;
      rbit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rbit_q  <= rbit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q  <= up_d;
    mid_q <= mid_d;
    if (accept) begin
      kind_q     <= req_type_i;
      row_idx_q  <= row_ext[RW-1:0];
      col_idx_q  <= col_i[CLW-1:0];
      alive_q    <= alive_i;
      in_board_q <= in_board;
    end
  end

  lge_board_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  lge_row_rule #(
    .COLS (MAX_COLS)
  ) u_rule (
    .up_i   (up_q),
    .mid_i  (mid_q),
    .dn_i   (dn),
    .mask_i (mask),
    .next_o (rule_next)
  );

  assign in_stall_o   = (state_q != lge_pkg::ST_IDLE);
  assign out_valid_o  = (state_q == lge_pkg::ST_RESP);
  assign read_alive_o = rbit_q;
  assign done_kind_o  = kind_q;

`ifndef NO_ASSERTIONS
  a_busy_while_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  a_write_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == lge_pkg::ST_CELL || state_q == lge_pkg::ST_ADV))
    else $error("board write outside a request");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lge_pkg::ST_ADV) |-> (cnt_q <= rows_eff))
    else $error("advance row counter past board");

  a_nop_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == lge_pkg::REQ_NOP) |=> (out_valid_o && !read_alive_o))
    else $error("unused request type result wrong");
`endif

endmodule

`default_nettype wire
